### hw/rtl/chp_pkg.sv
// Shared types, constants and arithmetic helpers for the cascaded height PID block.
// Used by every module under hw/rtl; depends on nothing else.
package chp_pkg;

  // Fixed-point format of the controller.
  localparam int FRAC_BITS = 16;

  // Shared multiplier geometry: unsigned gain/time operand times signed signal.
  localparam int MUL_A_W  = 24;
  localparam int MUL_B_W  = 42;
  localparam int MUL_HALF = MUL_A_W / 2;
  localparam int PP_W     = MUL_B_W + MUL_HALF + 1;
  localparam int PROD_W   = MUL_B_W + MUL_A_W;

  // Working widths of the datapath.
  localparam int SUM_W    = 48;
  localparam int SIG_W    = 32;
  localparam int OUT_W    = 26;
  localparam int IINT_W   = 25;
  localparam int GAIN_W   = 24;
  localparam int TIME_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_KI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_KD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_KP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_KI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_KD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_DT  = 3'd6;

  // Power-up values of the configuration registers.
  localparam logic [GAIN_W-1:0] RST_INNER_KP = 24'd6554;
  localparam logic [GAIN_W-1:0] RST_INNER_KI = 24'd5243;
  localparam logic [GAIN_W-1:0] RST_INNER_KD = 24'd524288;
  localparam logic [GAIN_W-1:0] RST_OUTER_KP = 24'd32768;
  localparam logic [GAIN_W-1:0] RST_OUTER_KI = 24'd0;
  localparam logic [GAIN_W-1:0] RST_OUTER_KD = 24'd163840;
  localparam logic [TIME_W-1:0] RST_OUTER_DT = 16'd2458;

  // Clamp limits in Q16.16: 200, 300 and 500.
  localparam logic signed [SUM_W-1:0] LIM_200 = 48'sd13107200;
  localparam logic signed [SUM_W-1:0] LIM_300 = 48'sd19660800;
  localparam logic signed [SUM_W-1:0] LIM_500 = 48'sd32768000;

  // Signed 32-bit range used to saturate the height error.
  localparam logic signed [PROD_W-1:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN = -66'sd2147483648;

  // Rounding offsets for the Q16 rescale and for the halved (Q17) rescale.
  localparam logic signed [PROD_W-1:0] HALF_Q16 = 66'sd32768;
  localparam logic signed [PROD_W-1:0] HALF_Q17 = 66'sd65536;

  // Multiply steps of one control tick, in issue order.
  typedef enum logic [3:0] {
    OP_IINC1,
    OP_IINC2,
    OP_FF,
    OP_PROP,
    OP_DAMP1,
    OP_DAMP2,
    OP_ERR,
    OP_OINC1,
    OP_OINC2,
    OP_VEL,
    OP_OD
  } chp_op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WAIT,
    ST_THRUST,
    ST_TARGET,
    ST_FIN
  } chp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    mul_start;
    logic    wb;
    chp_op_t op;
    logic    thrust;
    logic    target;
    logic    fin;
  } chp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic run_outer;
  } chp_status_t;

  // Round to nearest by 2^-16, ties toward plus infinity.
  function automatic logic signed [PROD_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
    round_q16 = (p + HALF_Q16) >>> FRAC_BITS;
  endfunction

  // Round to nearest by 2^-17, ties toward plus infinity.
  function automatic logic signed [PROD_W-1:0] round_q17(input logic signed [PROD_W-1:0] p);
    round_q17 = (p + HALF_Q17) >>> (FRAC_BITS + 1);
  endfunction

  // Symmetric clamp to plus or minus lim.
  function automatic logic signed [SUM_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] x,
                                                        input logic signed [SUM_W-1:0] lim);
    if (x > lim) begin
      clamp_sym = lim;
    end else if (x < -lim) begin
      clamp_sym = -lim;
    end else begin
      clamp_sym = x;
    end
  endfunction

endpackage

### hw/rtl/chp_mul.sv
// Shared partial-product multiplier: unsigned 24-bit operand times signed 42-bit operand.
// Depends on chp_pkg for its widths.
module chp_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [chp_pkg::MUL_A_W-1:0]         a,
  input  logic signed [chp_pkg::MUL_B_W-1:0]  b,
  output logic                                done,
  output logic signed [chp_pkg::PROD_W-1:0]   prod
);
  import chp_pkg::*;

  logic [MUL_A_W-1:0]         a_hold;
  logic signed [MUL_B_W-1:0]  b_hold;
  logic signed [PP_W-1:0]     pp;
  logic signed [PROD_W-1:0]   acc;
  logic [1:0]                 phase;

  // Phase counter: 1 forms the low partial product, 2 the high one, 3 accumulates.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= (phase == 2'd3);
      if (start) begin
        phase <= 2'd1;
      end else if (phase != 2'd0) begin
        phase <= phase + 2'd1;
      end
    end
  end

  // Operand capture and partial-product accumulation.
  always_ff @(posedge clk) begin
    if (start) begin
      a_hold <= a;
      b_hold <= b;
    end
    case (phase)
      2'd1: begin
        pp <= b_hold * $signed({1'b0, a_hold[MUL_HALF-1:0]});
      end
      2'd2: begin
        acc <= {{(PROD_W-PP_W){pp[PP_W-1]}}, pp};
        pp  <= b_hold * $signed({1'b0, a_hold[MUL_A_W-1:MUL_HALF]});
      end
      2'd3: begin
        acc <= acc + ({{(PROD_W-PP_W){pp[PP_W-1]}}, pp} <<< MUL_HALF);
      end
      default: begin
      end
    endcase
  end

  assign prod = acc;

endmodule

### hw/rtl/chp_datapath.sv
// Datapath of the cascaded height PID: configuration, loop state, operand
// selection, write-back and the output register. Depends on chp_pkg and chp_mul.
module chp_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [chp_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [chp_pkg::GAIN_W-1:0]              cfg_data,
  input  logic signed [chp_pkg::SIG_W-1:0]        measured_height,
  input  logic signed [chp_pkg::SIG_W-1:0]        fused_speed,
  input  logic signed [chp_pkg::SIG_W-1:0]        sensor_speed,
  input  logic signed [chp_pkg::SIG_W-1:0]        vertical_accel,
  input  logic signed [chp_pkg::SIG_W-1:0]        height_setpoint,
  input  logic [chp_pkg::TIME_W-1:0]              step_time,
  input  logic                                    run_outer,
  input  logic                                    clear_loops,
  input  chp_pkg::chp_cmd_t                       cmd,
  output chp_pkg::chp_status_t                    status,
  output logic signed [chp_pkg::OUT_W-1:0]        thrust_adjust,
  output logic signed [chp_pkg::OUT_W-1:0]        speed_demand
);
  import chp_pkg::*;

  // Configuration registers.
  logic [GAIN_W-1:0] inner_kp, inner_ki, inner_kd;
  logic [GAIN_W-1:0] outer_kp, outer_ki, outer_kd;
  logic [TIME_W-1:0] outer_step_time;

  // Captured transaction fields.
  logic signed [SIG_W-1:0] height, fused, sensor, accel, setpoint;
  logic [TIME_W-1:0]       dt;
  logic                    do_outer;

  // Loop state.
  logic signed [OUT_W-1:0]  speed_target;
  logic signed [IINT_W-1:0] inner_integral;
  logic signed [OUT_W-1:0]  outer_integral;
  logic signed [SIG_W-1:0]  outer_prev_error;

  // Working registers.
  logic signed [MUL_B_W-1:0] t1;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SIG_W-1:0]   err;
  logic signed [OUT_W-1:0]   thrust;

  // Multiplier interface and derived values.
  logic [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  mul_prod;
  logic signed [PROD_W-1:0]  r16, r17;
  logic signed [SIG_W-1:0]   err_sat;
  logic signed [MUL_B_W-1:0] tgt_x, fused_x, sensor_x, accel_x, height_x, setp_x;
  logic signed [MUL_B_W-1:0] err_x, prev_x;
  logic signed [SUM_W-1:0]   iint_sum, oint_sum, thrust_sum, target_sum;
  logic signed [SUM_W-1:0]   iint_clamp, oint_clamp, thrust_clamp, target_clamp;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_kp        <= RST_INNER_KP;
      inner_ki        <= RST_INNER_KI;
      inner_kd        <= RST_INNER_KD;
      outer_kp        <= RST_OUTER_KP;
      outer_ki        <= RST_OUTER_KI;
      outer_kd        <= RST_OUTER_KD;
      outer_step_time <= RST_OUTER_DT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INNER_KP: inner_kp        <= cfg_data;
        CFG_INNER_KI: inner_ki        <= cfg_data;
        CFG_INNER_KD: inner_kd        <= cfg_data;
        CFG_OUTER_KP: outer_kp        <= cfg_data;
        CFG_OUTER_KI: outer_ki        <= cfg_data;
        CFG_OUTER_KD: outer_kd        <= cfg_data;
        CFG_OUTER_DT: outer_step_time <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sign extension of the signals to the multiplier operand width.
  assign tgt_x    = {{(MUL_B_W-OUT_W){speed_target[OUT_W-1]}}, speed_target};
  assign fused_x  = {{(MUL_B_W-SIG_W){fused[SIG_W-1]}}, fused};
  assign sensor_x = {{(MUL_B_W-SIG_W){sensor[SIG_W-1]}}, sensor};
  assign accel_x  = {{(MUL_B_W-SIG_W){accel[SIG_W-1]}}, accel};
  assign height_x = {{(MUL_B_W-SIG_W){height[SIG_W-1]}}, height};
  assign setp_x   = {{(MUL_B_W-SIG_W){setpoint[SIG_W-1]}}, setpoint};
  assign err_x    = {{(MUL_B_W-SIG_W){err[SIG_W-1]}}, err};
  assign prev_x   = {{(MUL_B_W-SIG_W){outer_prev_error[SIG_W-1]}}, outer_prev_error};

  // Operand selection for the current multiply step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_IINC1: begin
        mul_a = inner_ki;
        mul_b = tgt_x - sensor_x;
      end
      OP_IINC2, OP_DAMP2: begin
        mul_a = {{(MUL_A_W-TIME_W){1'b0}}, dt};
        mul_b = t1;
      end
      OP_FF: begin
        mul_a = inner_kp;
        mul_b = tgt_x;
      end
      OP_PROP: begin
        mul_a = inner_kp;
        mul_b = tgt_x - fused_x;
      end
      OP_DAMP1: begin
        mul_a = inner_kd;
        mul_b = -accel_x;
      end
      OP_ERR: begin
        mul_a = outer_kp;
        mul_b = setp_x - height_x;
      end
      OP_OINC1: begin
        mul_a = outer_ki;
        mul_b = err_x;
      end
      OP_OINC2: begin
        mul_a = {{(MUL_A_W-TIME_W){1'b0}}, outer_step_time};
        mul_b = t1;
      end
      OP_VEL: begin
        mul_a = {{(MUL_A_W-TIME_W){1'b0}}, outer_step_time};
        mul_b = -fused_x;
      end
      OP_OD: begin
        mul_a = outer_kd;
        mul_b = t1 + err_x - prev_x;
      end
      default: begin
      end
    endcase
  end

  chp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Rescaled product, saturated height error and the clamp sums.
  always_comb begin
    r16 = round_q16(mul_prod);
    r17 = round_q17(mul_prod);
    if (r16 > S32_MAX) begin
      err_sat = S32_MAX[SIG_W-1:0];
    end else if (r16 < S32_MIN) begin
      err_sat = S32_MIN[SIG_W-1:0];
    end else begin
      err_sat = r16[SIG_W-1:0];
    end
    iint_sum = {{(SUM_W-IINT_W){inner_integral[IINT_W-1]}}, inner_integral} + r16[SUM_W-1:0];
    oint_sum = {{(SUM_W-OUT_W){outer_integral[OUT_W-1]}}, outer_integral} + r16[SUM_W-1:0];
    thrust_sum = sum + {{(SUM_W-IINT_W){inner_integral[IINT_W-1]}}, inner_integral};
    target_sum = sum + {{(SUM_W-SIG_W){err[SIG_W-1]}}, err}
               + {{(SUM_W-OUT_W){outer_integral[OUT_W-1]}}, outer_integral};
    iint_clamp   = clamp_sym(iint_sum, LIM_200);
    oint_clamp   = clamp_sym(oint_sum, LIM_300);
    thrust_clamp = clamp_sym(thrust_sum, LIM_300);
    target_clamp = clamp_sym(target_sum, LIM_500);
  end

  // Loop state: reset to zero, all but the target cleared on request, then updated.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_target     <= '0;
      inner_integral   <= '0;
      outer_integral   <= '0;
      outer_prev_error <= '0;
    end else begin
      if (cmd.load && clear_loops) begin
        inner_integral   <= '0;
        outer_integral   <= '0;
        outer_prev_error <= '0;
      end
      if (cmd.wb && cmd.op == OP_IINC2) begin
        inner_integral <= iint_clamp[IINT_W-1:0];
      end
      if (cmd.wb && cmd.op == OP_OINC2) begin
        outer_integral <= oint_clamp[OUT_W-1:0];
      end
      if (cmd.target) begin
        speed_target     <= target_clamp[OUT_W-1:0];
        outer_prev_error <= err;
      end
    end
  end

  // Transaction capture, working registers and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      height   <= measured_height;
      fused    <= fused_speed;
      sensor   <= sensor_speed;
      accel    <= vertical_accel;
      setpoint <= height_setpoint;
      dt       <= step_time;
      do_outer <= run_outer;
      sum      <= '0;
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_IINC1, OP_DAMP1, OP_OINC1, OP_VEL: t1 <= r16[MUL_B_W-1:0];
        OP_FF, OP_PROP, OP_DAMP2:             sum <= sum + r16[SUM_W-1:0];
        OP_ERR:                               err <= err_sat;
        OP_OD:                                sum <= r17[SUM_W-1:0];
        default: begin
        end
      endcase
    end
    if (cmd.thrust) begin
      thrust <= thrust_clamp[OUT_W-1:0];
    end
    if (cmd.fin) begin
      thrust_adjust <= thrust;
      speed_demand  <= speed_target;
    end
  end

  assign status.mul_done  = mul_done;
  assign status.run_outer = do_outer;

endmodule

### hw/rtl/chp_ctrl.sv
// Controller of the cascaded height PID: sequences the multiply steps of one
// tick and owns the handshakes. Depends on chp_pkg.
module chp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  chp_pkg::chp_status_t  status,
  output chp_pkg::chp_cmd_t     cmd
);
  import chp_pkg::*;

  chp_state_t state, state_next;
  chp_op_t    op, op_next;
  logic       out_valid_next;
  logic       slot_free;

  // Order of the multiply steps within each loop.
  function automatic chp_op_t follow_op(input chp_op_t cur);
    case (cur)
      OP_IINC1: follow_op = OP_IINC2;
      OP_IINC2: follow_op = OP_FF;
      OP_FF:    follow_op = OP_PROP;
      OP_PROP:  follow_op = OP_DAMP1;
      OP_DAMP1: follow_op = OP_DAMP2;
      OP_ERR:   follow_op = OP_OINC1;
      OP_OINC1: follow_op = OP_OINC2;
      OP_OINC2: follow_op = OP_VEL;
      OP_VEL:   follow_op = OP_OD;
      default:  follow_op = OP_IINC1;
    endcase
  endfunction

  assign slot_free = !out_valid || out_ready;

  // Next state and next step.
  always_comb begin
    state_next = state;
    op_next    = op;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL;
          op_next    = OP_IINC1;
        end
      end
      ST_MUL: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.mul_done) begin
          if (op == OP_DAMP2) begin
            state_next = ST_THRUST;
          end else if (op == OP_OD) begin
            state_next = ST_TARGET;
          end else begin
            state_next = ST_MUL;
            op_next    = follow_op(op);
          end
        end
      end
      ST_THRUST: begin
        if (status.run_outer) begin
          state_next = ST_MUL;
          op_next    = OP_ERR;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_TARGET: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath and handshake outputs.
  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.mul_start = (state == ST_MUL);
    cmd.wb        = (state == ST_WAIT) && status.mul_done;
    cmd.op        = op;
    cmd.thrust    = (state == ST_THRUST);
    cmd.target    = (state == ST_TARGET);
    cmd.fin       = (state == ST_FIN) && slot_free;
  end

  // The output register holds one finished result until it is taken.
  always_comb begin
    if (cmd.fin) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_IINC1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/cascaded_height_pid_top.sv
// Cascaded height PID: one control tick per input transaction, one result each.
// Instantiates chp_ctrl and chp_datapath; depends on chp_pkg.
//
// Each input transaction is one control tick: the vertical-speed loop runs first
// and gives thrust_adjust, then, when run_outer is set, the height loop runs and
// its clamped output becomes the speed target reported as speed_demand. All
// arithmetic is Q16.16 fixed point with round-to-nearest rescaling. Every product
// goes through a single shared multiplier, one product at a time: six products
// for the speed loop alone and eleven with the height loop as well. A new input
// transaction is accepted only once the previous result is in the output register.
// A result that is not taken holds the block only at the end of the following tick.
// Configuration writes take effect at once and are meant to happen while no tick
// is in progress.
module cascaded_height_pid_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [chp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [chp_pkg::GAIN_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [chp_pkg::SIG_W-1:0]      measured_height,
  input  logic signed [chp_pkg::SIG_W-1:0]      fused_speed,
  input  logic signed [chp_pkg::SIG_W-1:0]      sensor_speed,
  input  logic signed [chp_pkg::SIG_W-1:0]      vertical_accel,
  input  logic signed [chp_pkg::SIG_W-1:0]      height_setpoint,
  input  logic [chp_pkg::TIME_W-1:0]            step_time,
  input  logic                                  run_outer,
  input  logic                                  clear_loops,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [chp_pkg::OUT_W-1:0]      thrust_adjust,
  output logic signed [chp_pkg::OUT_W-1:0]      speed_demand
);
  import chp_pkg::*;

  chp_cmd_t    cmd;
  chp_status_t status;

  // Sequencer for the multiply steps and the handshakes.
  chp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, loop state and configuration.
  chp_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .measured_height (measured_height),
    .fused_speed     (fused_speed),
    .sensor_speed    (sensor_speed),
    .vertical_accel  (vertical_accel),
    .height_setpoint (height_setpoint),
    .step_time       (step_time),
    .run_outer       (run_outer),
    .clear_loops     (clear_loops),
    .cmd             (cmd),
    .status          (status),
    .thrust_adjust   (thrust_adjust),
    .speed_demand    (speed_demand)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the cascaded height PID block (speed loop plus height loop).
// Depends on chp_pkg and cascaded_height_pid_top; a built-in fixed-point predictor checks
// every output transaction against the expected thrust and speed demand.
`timescale 1ns / 1ps

module tb_top;
  import chp_pkg::*;

  localparam int     MM          = 65536;
  localparam int     CYCLE_LIMIT = 800000;
  localparam int     SETTLE      = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam longint ERR_HI      = 64'sd2147483647;
  localparam longint ERR_LO      = -64'sd2147483648;

  // One control tick as presented on the input channel.
  typedef struct packed {
    logic signed [SIG_W-1:0] height;
    logic signed [SIG_W-1:0] fused;
    logic signed [SIG_W-1:0] sensor;
    logic signed [SIG_W-1:0] accel;
    logic signed [SIG_W-1:0] setpoint;
    logic [TIME_W-1:0]       dt;
    logic                    run_outer;
    logic                    clear;
  } tick_t;

  // Expected output transaction.
  typedef struct packed {
    logic [OUT_W-1:0] thrust;
    logic [OUT_W-1:0] demand;
  } ctrl_out_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [GAIN_W-1:0]       cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [SIG_W-1:0] measured_height;
  logic signed [SIG_W-1:0] fused_speed;
  logic signed [SIG_W-1:0] sensor_speed;
  logic signed [SIG_W-1:0] vertical_accel;
  logic signed [SIG_W-1:0] height_setpoint;
  logic [TIME_W-1:0]       step_time;
  logic                    run_outer;
  logic                    clear_loops;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] thrust_adjust;
  logic signed [OUT_W-1:0] speed_demand;

  cascaded_height_pid_top dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .measured_height (measured_height),
    .fused_speed     (fused_speed),
    .sensor_speed    (sensor_speed),
    .vertical_accel  (vertical_accel),
    .height_setpoint (height_setpoint),
    .step_time       (step_time),
    .run_outer       (run_outer),
    .clear_loops     (clear_loops),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .thrust_adjust   (thrust_adjust),
    .speed_demand    (speed_demand)
  );

  // Gains and timing as the block should hold them.
  longint g_ikp, g_iki, g_ikd, g_okp, g_oki, g_okd, g_odt;
  // Controller state as the block should hold it.
  longint tgt_speed, spd_integ, hgt_integ, hgt_prev_err;

  tick_t     tick_queue[$];
  ctrl_out_t expected_outputs[$];
  tick_t     cur_tick;
  bit        in_taken;
  int        send_idle;
  int        recv_idle;
  int        err_count;
  int        n_checked;
  int        n_outer;
  int        n_clear;
  int        n_settings;
  int        cycle_count;

  // Round to nearest by 2^-s, ties toward plus infinity.
  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_to(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Advance the controller model by one tick and return the expected outputs.
  function automatic ctrl_out_t predict_tick(tick_t t);
    longint hgt, fus, sen, acc, sp, dt;
    longint tgt, ff, prop, damp, inc, thrust, err, vel, od;
    ctrl_out_t r;
    hgt = longint'($signed(t.height));
    fus = longint'($signed(t.fused));
    sen = longint'($signed(t.sensor));
    acc = longint'($signed(t.accel));
    sp  = longint'($signed(t.setpoint));
    dt  = longint'(t.dt);
    if (t.clear) begin
      spd_integ    = 0;
      hgt_integ    = 0;
      hgt_prev_err = 0;
    end
    // Speed loop against the stored target.
    tgt       = tgt_speed;
    ff        = rnd_shift(g_ikp * tgt, FRAC_BITS);
    prop      = rnd_shift(g_ikp * (tgt - fus), FRAC_BITS);
    damp      = rnd_shift(rnd_shift(g_ikd * (-acc), FRAC_BITS) * dt, FRAC_BITS);
    inc       = rnd_shift(rnd_shift(g_iki * (tgt - sen), FRAC_BITS) * dt, FRAC_BITS);
    spd_integ = clamp_to(spd_integ + inc, longint'(LIM_200));
    thrust    = clamp_to(ff + prop + damp + spd_integ, longint'(LIM_300));
    // Height loop; its output becomes the new speed target.
    if (t.run_outer) begin
      err = rnd_shift(g_okp * (sp - hgt), FRAC_BITS);
      if (err > ERR_HI) err = ERR_HI;
      if (err < ERR_LO) err = ERR_LO;
      inc          = rnd_shift(rnd_shift(g_oki * err, FRAC_BITS) * g_odt, FRAC_BITS);
      hgt_integ    = clamp_to(hgt_integ + inc, longint'(LIM_300));
      vel          = rnd_shift(-fus * g_odt, FRAC_BITS);
      od           = rnd_shift(g_okd * (vel + err - hgt_prev_err), FRAC_BITS + 1);
      tgt_speed    = clamp_to(err + hgt_integ + od, longint'(LIM_500));
      hgt_prev_err = err;
    end
    r.thrust = thrust[OUT_W-1:0];
    r.demand = tgt_speed[OUT_W-1:0];
    return r;
  endfunction

  function automatic void add_tick(logic signed [SIG_W-1:0] h, logic signed [SIG_W-1:0] f,
                                   logic signed [SIG_W-1:0] s, logic signed [SIG_W-1:0] a,
                                   logic signed [SIG_W-1:0] sp, logic [TIME_W-1:0] dt,
                                   logic ro, logic cl);
    tick_t t;
    t.height    = h;
    t.fused     = f;
    t.sensor    = s;
    t.accel     = a;
    t.setpoint  = sp;
    t.dt        = dt;
    t.run_outer = ro;
    t.clear     = cl;
    tick_queue.push_back(t);
  endfunction

  // Uniform value in [-span, span].
  function automatic logic signed [SIG_W-1:0] near_zero(int unsigned span);
    longint v;
    v = longint'($urandom_range(2 * span)) - longint'(span);
    return v[SIG_W-1:0];
  endfunction

  // Full-range value with extra weight on the extremes.
  function automatic logic signed [SIG_W-1:0] wide_value();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return near_zero(32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return GAIN_W'($urandom_range(0, 24'hFF_FFFF));
      default: return GAIN_W'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  // Mostly plausible flight ticks, the rest full-range noise.
  function automatic void queue_random(int n);
    tick_t t;
    repeat (n) begin
      if ($urandom_range(99) < 65) begin
        t.height    = near_zero(5000 * MM);
        t.fused     = near_zero(2000 * MM);
        t.sensor    = near_zero(2000 * MM);
        t.accel     = near_zero(20000 * MM);
        t.setpoint  = near_zero(5000 * MM);
        t.dt        = TIME_W'($urandom_range(131, 1311));
        t.run_outer = ($urandom_range(2) == 0);
        t.clear     = ($urandom_range(49) == 0);
      end else begin
        t.height    = wide_value();
        t.fused     = wide_value();
        t.sensor    = wide_value();
        t.accel     = wide_value();
        t.setpoint  = wide_value();
        case ($urandom_range(3))
          0:       t.dt = '0;
          1:       t.dt = '1;
          default: t.dt = TIME_W'($urandom_range(0, 16'hFFFF));
        endcase
        t.run_outer = ($urandom_range(1) == 1);
        t.clear     = ($urandom_range(3) == 0);
      end
      tick_queue.push_back(t);
    end
  endfunction

  // Register write through the configuration port, mirrored into the model.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_INNER_KP: g_ikp = longint'(data);
      CFG_INNER_KI: g_iki = longint'(data);
      CFG_INNER_KD: g_ikd = longint'(data);
      CFG_OUTER_KP: g_okp = longint'(data);
      CFG_OUTER_KI: g_oki = longint'(data);
      CFG_OUTER_KD: g_okd = longint'(data);
      CFG_OUTER_DT: g_odt = longint'(data[TIME_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] ikp, input logic [GAIN_W-1:0] iki,
                             input logic [GAIN_W-1:0] ikd, input logic [GAIN_W-1:0] okp,
                             input logic [GAIN_W-1:0] oki, input logic [GAIN_W-1:0] okd,
                             input logic [GAIN_W-1:0] odt);
    write_reg(CFG_INNER_KP, ikp);
    write_reg(CFG_INNER_KI, iki);
    write_reg(CFG_INNER_KD, ikd);
    write_reg(CFG_OUTER_KP, okp);
    write_reg(CFG_OUTER_KI, oki);
    write_reg(CFG_OUTER_KD, okd);
    write_reg(CFG_OUTER_DT, odt);
    n_settings++;
  endtask

  // Wait until every queued tick has been sent and answered, then let the block settle.
  task automatic drain();
    @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Input channel driver and output back-pressure, updated on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_tick = tick_queue.pop_front();
          measured_height <= cur_tick.height;
          fused_speed     <= cur_tick.fused;
          sensor_speed    <= cur_tick.sensor;
          vertical_accel  <= cur_tick.accel;
          height_setpoint <= cur_tick.setpoint;
          step_time       <= cur_tick.dt;
          run_outer       <= cur_tick.run_outer;
          clear_loops     <= cur_tick.clear;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: check output transactions, then predict accepted input transactions.
  always @(posedge clk) begin
    ctrl_out_t exp_out;
    tick_t     t;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $error("Output transaction with no tick outstanding");
          err_count++;
        end else begin
          exp_out = expected_outputs.pop_front();
          n_checked++;
          if (thrust_adjust !== exp_out.thrust) begin
            $error("thrust_adjust mismatch: expected %0d, actual %0d",
                   $signed(exp_out.thrust), thrust_adjust);
            err_count++;
          end
          if (speed_demand !== exp_out.demand) begin
            $error("speed_demand mismatch: expected %0d, actual %0d",
                   $signed(exp_out.demand), speed_demand);
            err_count++;
          end
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        t.height    = measured_height;
        t.fused     = fused_speed;
        t.sensor    = sensor_speed;
        t.accel     = vertical_accel;
        t.setpoint  = height_setpoint;
        t.dt        = step_time;
        t.run_outer = run_outer;
        t.clear     = clear_loops;
        if (t.run_outer) n_outer++;
        if (t.clear) n_clear++;
        expected_outputs.push_back(predict_tick(t));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("Timeout with %0d ticks pending and %0d results outstanding",
             tick_queue.size(), expected_outputs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    out_ready       = 1'b0;
    measured_height = '0;
    fused_speed     = '0;
    sensor_speed    = '0;
    vertical_accel  = '0;
    height_setpoint = '0;
    step_time       = '0;
    run_outer       = 1'b0;
    clear_loops     = 1'b0;
    err_count       = 0;
    n_checked       = 0;
    n_outer         = 0;
    n_clear         = 0;
    n_settings      = 1;
    cycle_count     = 0;
    g_ikp = longint'(RST_INNER_KP);
    g_iki = longint'(RST_INNER_KI);
    g_ikd = longint'(RST_INNER_KD);
    g_okp = longint'(RST_OUTER_KP);
    g_oki = longint'(RST_OUTER_KI);
    g_okd = longint'(RST_OUTER_KD);
    g_odt = longint'(RST_OUTER_DT);
    tgt_speed    = 0;
    spd_integ    = 0;
    hgt_integ    = 0;
    hgt_prev_err = 0;
    send_idle    = 15;
    recv_idle    = 55;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks at power-up gains.
    add_tick(0, 0, 0, 0, 0, 16'd0, 1'b0, 1'b0);
    add_tick(0, 0, 0, 0, 0, 16'hFFFF, 1'b1, 1'b0);
    add_tick(0, 0, 0, 0, 1000 * MM, 16'd655, 1'b1, 1'b0);
    add_tick(50 * MM, 100 * MM, 90 * MM, 200 * MM, 1000 * MM, 16'd655, 1'b0, 1'b0);
    add_tick(100 * MM, 150 * MM, 140 * MM, -300 * MM, 1000 * MM, 16'd655, 1'b1, 1'b0);
    // Height error at both extremes; the positive one saturates.
    add_tick(32'sh8000_0000, 0, 0, 0, 32'sh7FFF_FFFF, 16'd655, 1'b1, 1'b0);
    add_tick(32'sh7FFF_FFFF, 0, 0, 0, 32'sh8000_0000, 16'd655, 1'b1, 1'b0);
    // Clear together with a height update, then clear alone.
    add_tick(200 * MM, -50 * MM, -40 * MM, 10 * MM, 500 * MM, 16'd655, 1'b1, 1'b1);
    add_tick(200 * MM, 0, 0, 0, 500 * MM, 16'd655, 1'b0, 1'b1);
    add_tick(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0, 16'hFFFF, 1'b1, 1'b0);
    add_tick(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 16'hFFFF, 1'b1, 1'b0);
    add_tick(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 16'hFFFF, 1'b1, 1'b1);
    add_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    // Drive the speed integrator into its clamps, then back.
    repeat (4) add_tick(0, 0, 32'sh8000_0000, 0, 1000 * MM, 16'hFFFF, 1'b1, 1'b0);
    repeat (3) add_tick(0, 0, 32'sh7FFF_FFFF, 0, -1000 * MM, 16'hFFFF, 1'b1, 1'b0);
    add_tick(-1, 1, -1, 1, 0, 16'd1, 1'b1, 1'b0);
    drain();

    // Moderate gains.
    write_gains(GAIN_W'($urandom_range(0, 1 << 18)), GAIN_W'($urandom_range(0, 1 << 18)),
                GAIN_W'($urandom_range(0, 1 << 18)), GAIN_W'($urandom_range(0, 1 << 18)),
                GAIN_W'($urandom_range(0, 1 << 18)), GAIN_W'($urandom_range(0, 1 << 18)),
                GAIN_W'($urandom_range(100, 6000)));
    queue_random(390);
    drain();

    // Every register at its maximum; the unused index must change nothing.
    write_gains('1, '1, '1, '1, '1, '1, '1);
    write_reg(CFG_UNUSED, GAIN_W'($urandom));
    queue_random(390);
    drain();

    // Swap the idle pattern; every register at zero.
    send_idle = 55;
    recv_idle = 15;
    write_gains('0, '0, '0, '0, '0, '0, '0);
    queue_random(390);
    drain();

    // Gains anywhere in range.
    write_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                rand_gain(), GAIN_W'($urandom));
    queue_random(390);
    drain();

    // No idling; power-up gains restored except the outer KI, with junk above the period's 16 bits.
    send_idle = 0;
    recv_idle = 0;
    write_gains(RST_INNER_KP, RST_INNER_KI, RST_INNER_KD, RST_OUTER_KP, 24'd3000,
                RST_OUTER_KD, {8'hA5, RST_OUTER_DT});
    queue_random(390);
    drain();

    if (expected_outputs.size() != 0) begin
      $error("%0d expected results never arrived", expected_outputs.size());
      err_count++;
    end
    $display("Checked %0d control ticks (%0d with height update, %0d with loop clear)",
             n_checked, n_outer, n_clear);
    $display("across %0d gain settings and three handshake idle patterns.", n_settings);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/chp_pkg.sv
hw/rtl/chp_mul.sv
hw/rtl/chp_datapath.sv
hw/rtl/chp_ctrl.sv
hw/rtl/cascaded_height_pid_top.sv
tb/tb_top.sv
